// ===== rtl/pde_pkg.sv =====
package pde_pkg;

  localparam int unsigned POSITION_BITS_DEF = 24;
  localparam int unsigned CH_W              = 8;
  localparam int unsigned SYM_W             = 16;
  localparam int unsigned ALPHA_W           = 7;
  localparam int unsigned BASE_W            = ALPHA_W + 1;
  localparam int unsigned CFG_IDX_W         = 1;
  localparam int unsigned CFG_DATA_W        = ALPHA_W;

  // quotient bits retired per divider cycle
  localparam int unsigned RADIX_BITS = 2;
  localparam int unsigned ITERS      = SYM_W / RADIX_BITS;
  localparam int unsigned CNT_W      = $clog2(ITERS);

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'd1;

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 7'd1;
  localparam logic [CH_W-1:0]    CH_MAX      = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_DONE
  } pde_state_t;

  typedef enum logic [1:0] {
    ROT_0 = 2'd0,
    ROT_1 = 2'd1,
    ROT_2 = 2'd2
  } pde_rot_t;

endpackage

// ===== rtl/pixel_digit_embed_extract.sv =====
// pixel_digit_embed_extract: hides a 16-bit symbol in one pixel as two base-(2*alpha+1)
// digits, or reads it back. An accepted item passes through a load step, the serial
// divide/multiply run and a result step before out_valid; the 2-bit-per-cycle divider
// loop takes no new item until its result is loaded into the output register.
// in_ready is high only while the datapath is idle; a stalled result holds the next item.
// Reset (rst_n low, synchronous): mode embed, alpha 1, rotation index 0, no valid items.
module pixel_digit_embed_extract #(
  parameter int unsigned POSITION_BITS = pde_pkg::POSITION_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [pde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pde_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input item channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [POSITION_BITS-1:0]         in_pixel_position,
  input  logic [pde_pkg::CH_W-1:0]         in_chan0_in,
  input  logic [pde_pkg::CH_W-1:0]         in_chan1_in,
  input  logic [pde_pkg::CH_W-1:0]         in_chan2_in,
  input  logic [pde_pkg::SYM_W-1:0]        in_symbol_in,
  input  logic                             in_last_pixel,
  // result item channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [POSITION_BITS-1:0]         out_pixel_position_out,
  output logic [pde_pkg::CH_W-1:0]         out_chan0_out,
  output logic [pde_pkg::CH_W-1:0]         out_chan1_out,
  output logic [pde_pkg::CH_W-1:0]         out_chan2_out,
  output logic [pde_pkg::SYM_W-1:0]        out_symbol_out,
  output logic                             out_symbol_too_large
);

  localparam int unsigned CH_W   = pde_pkg::CH_W;
  localparam int unsigned SYM_W  = pde_pkg::SYM_W;
  localparam int unsigned BASE_W = pde_pkg::BASE_W;
  localparam int unsigned CNT_W  = pde_pkg::CNT_W;

  // ---------------- configuration ----------------
  logic                           mode_r;
  logic [pde_pkg::ALPHA_W-1:0]    alpha_r;
  logic [BASE_W-1:0]              base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= pde_pkg::MODE_EMBED;
      alpha_r <= pde_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pde_pkg::REG_MODE:  mode_r  <= cfg_data[0];
        pde_pkg::REG_ALPHA: alpha_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // b = 2*alpha + 1
  assign base = {alpha_r, 1'b1};

  // ---------------- state ----------------
  pde_pkg::pde_state_t state_r, state_nxt;
  pde_pkg::pde_rot_t   rot_r, rot_nxt;      // rotation index of the next item
  pde_pkg::pde_rot_t   role_r, role_nxt;    // rotation of the item in flight
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // item payload
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [CH_W-1:0]          ch0_r, ch0_nxt, ch1_r, ch1_nxt, ch2_r, ch2_nxt;
  logic [CH_W-1:0]          hi_r, hi_nxt, lo_r, lo_nxt, ref_r, ref_nxt;

  // serial datapath: divider dividend/quotient and remainder, multiplier acc
  logic [SYM_W-1:0]  dq_r, dq_nxt;
  logic [CH_W-1:0]   rem_r, rem_nxt;
  logic [SYM_W-1:0]  acc_r, acc_nxt;
  logic [SYM_W-1:0]  mcand_r, mcand_nxt;
  logic [BASE_W-1:0] mplier_r, mplier_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [POSITION_BITS-1:0] opos_r, opos_nxt;
  logic [CH_W-1:0]          oc0_r, oc0_nxt, oc1_r, oc1_nxt, oc2_r, oc2_nxt;
  logic [SYM_W-1:0]         osym_r, osym_nxt;
  logic                     otl_r, otl_nxt;

  // combinational helpers
  logic               in_acc;
  logic               out_load;
  logic [CH_W-1:0]    sel_hi, sel_lo, sel_rf, clamp_hi, clamp_ref;
  logic [CH_W-1:0]    a8;
  logic [CH_W:0]      div_trial;
  logic [CH_W-1:0]    base_off, new_hi, new_lo;
  logic [CH_W-1:0]    res_c0, res_c1, res_c2;

  assign in_ready = (state_r == pde_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == pde_pkg::ST_DONE) && (!out_valid_r || out_ready);
  assign a8       = {1'b0, alpha_r};

  // role selection of the incoming pixel: hi = r, lo = r+1, reference = r+2
  always_comb begin
    unique case (rot_r)
      pde_pkg::ROT_1: begin
        sel_hi = in_chan1_in; sel_lo = in_chan2_in; sel_rf = in_chan0_in;
      end
      pde_pkg::ROT_2: begin
        sel_hi = in_chan2_in; sel_lo = in_chan0_in; sel_rf = in_chan1_in;
      end
      default: begin
        sel_hi = in_chan0_in; sel_lo = in_chan1_in; sel_rf = in_chan2_in;
      end
    endcase
  end

  // reference clamped to [alpha, 255-alpha]
  assign clamp_hi  = pde_pkg::CH_MAX - a8;
  assign clamp_ref = (sel_rf < a8)       ? a8 :
                     (sel_rf > clamp_hi) ? clamp_hi : sel_rf;

  // embedded digits: ref - alpha + digit, mod 256; quotient kept to 8 bits
  assign base_off = ref_r - a8;
  assign new_hi   = base_off + dq_r[CH_W-1:0];
  assign new_lo   = base_off + rem_r;

  // put the digit channels back in place
  always_comb begin
    res_c0 = ch0_r;
    res_c1 = ch1_r;
    res_c2 = ch2_r;
    if (mode_r == pde_pkg::MODE_EMBED) begin
      unique case (role_r)
        pde_pkg::ROT_1: begin res_c1 = new_hi; res_c2 = new_lo; end
        pde_pkg::ROT_2: begin res_c2 = new_hi; res_c0 = new_lo; end
        default:        begin res_c0 = new_hi; res_c1 = new_lo; end
      endcase
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt     = state_r;
    rot_nxt       = rot_r;
    role_nxt      = role_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    ch0_nxt       = ch0_r;
    ch1_nxt       = ch1_r;
    ch2_nxt       = ch2_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    ref_nxt       = ref_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    mplier_nxt    = mplier_r;
    out_valid_nxt = out_valid_r;
    opos_nxt      = opos_r;
    oc0_nxt       = oc0_r;
    oc1_nxt       = oc1_r;
    oc2_nxt       = oc2_r;
    osym_nxt      = osym_r;
    otl_nxt       = otl_r;
    div_trial     = '0;

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      pde_pkg::ST_IDLE: begin
        if (in_acc) begin
          pos_nxt  = in_pixel_position;
          ch0_nxt  = in_chan0_in;
          ch1_nxt  = in_chan1_in;
          ch2_nxt  = in_chan2_in;
          hi_nxt   = sel_hi;
          lo_nxt   = sel_lo;
          ref_nxt  = clamp_ref;
          dq_nxt   = in_symbol_in;
          role_nxt = rot_r;
          if (in_last_pixel || rot_r == pde_pkg::ROT_2) rot_nxt = pde_pkg::ROT_0;
          else if (rot_r == pde_pkg::ROT_1)             rot_nxt = pde_pkg::ROT_2;
          else                                          rot_nxt = pde_pkg::ROT_1;
          state_nxt = pde_pkg::ST_LOAD;
        end
      end
      pde_pkg::ST_LOAD: begin
        // digit differences, wrapped to 16 bits
        mcand_nxt  = SYM_W'({8'd0, hi_r}) + SYM_W'({9'd0, alpha_r})
                     - SYM_W'({8'd0, ref_r});
        acc_nxt    = SYM_W'({8'd0, lo_r}) + SYM_W'({9'd0, alpha_r})
                     - SYM_W'({8'd0, ref_r});
        mplier_nxt = base;
        rem_nxt    = '0;
        cnt_nxt    = '0;
        state_nxt  = pde_pkg::ST_RUN;
      end
      pde_pkg::ST_RUN: begin
        // restoring divide, RADIX_BITS quotient bits a cycle
        for (int k = 0; k < pde_pkg::RADIX_BITS; k++) begin
          div_trial = {rem_nxt, dq_nxt[SYM_W-1]};
          dq_nxt    = {dq_nxt[SYM_W-2:0], 1'b0};
          if (div_trial >= {1'b0, base}) begin
            rem_nxt   = CH_W'(div_trial - {1'b0, base});
            dq_nxt[0] = 1'b1;
          end else begin
            rem_nxt = div_trial[CH_W-1:0];
          end
        end
        // shift-add multiply, one multiplier bit a cycle, LSB first
        if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
        mcand_nxt  = {mcand_r[SYM_W-2:0], 1'b0};
        mplier_nxt = mplier_r >> 1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(pde_pkg::ITERS - 1)) state_nxt = pde_pkg::ST_DONE;
      end
      pde_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          opos_nxt      = pos_r;
          oc0_nxt       = res_c0;
          oc1_nxt       = res_c1;
          oc2_nxt       = res_c2;
          if (mode_r == pde_pkg::MODE_EMBED) begin
            osym_nxt = '0;
            // sym >= b*b exactly when the full quotient reaches b
            otl_nxt  = (dq_r >= SYM_W'(base));
          end else begin
            osym_nxt = acc_r;
            otl_nxt  = 1'b0;
          end
          state_nxt = pde_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pde_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pde_pkg::ST_IDLE;
      rot_r       <= pde_pkg::ROT_0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rot_r       <= rot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and datapath
  always_ff @(posedge clk) begin
    role_r   <= role_nxt;
    cnt_r    <= cnt_nxt;
    pos_r    <= pos_nxt;
    ch0_r    <= ch0_nxt;
    ch1_r    <= ch1_nxt;
    ch2_r    <= ch2_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    ref_r    <= ref_nxt;
    dq_r     <= dq_nxt;
    rem_r    <= rem_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    opos_r   <= opos_nxt;
    oc0_r    <= oc0_nxt;
    oc1_r    <= oc1_nxt;
    oc2_r    <= oc2_nxt;
    osym_r   <= osym_nxt;
    otl_r    <= otl_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_pixel_position_out = opos_r;
  assign out_chan0_out          = oc0_r;
  assign out_chan1_out          = oc1_r;
  assign out_chan2_out          = oc2_r;
  assign out_symbol_out         = osym_r;
  assign out_symbol_too_large   = otl_r;

  // ---------------- assertions ----------------
  a_accept_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == pde_pkg::ST_LOAD)
    else $error("accepted item did not enter load");

  a_rem_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pde_pkg::ST_RUN |-> rem_r < base)
    else $error("divider remainder not below base");

  a_extract_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && mode_r == pde_pkg::MODE_EXTRACT |=> !out_symbol_too_large)
    else $error("oversize flag set in extract mode");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(osym_r) && $stable(oc0_r))
    else $error("pending result overwritten");

endmodule
